### rtl/ltkm_pkg.sv
// ----------------------------------------------------------------------------
// ltkm_pkg
// Shared types and constants of the loser-tree k-way merge block.
// ----------------------------------------------------------------------------
package ltkm_pkg;

  // default sizing
  localparam int unsigned DEF_MAX_WAYS = 16;
  localparam int unsigned DEF_KEY_BITS = 64;

  // fixed port widths
  localparam int unsigned KEY_W = 64;
  localparam int unsigned WAY_W = 4;
  localparam int unsigned CFG_W = 5;

  // num_ways after reset
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LEAF = 2'd1,
    ST_CMP  = 2'd2,
    ST_EMIT = 2'd3
  } ltkm_state_e;

  // order class of a leaf: minus infinity, ordinary key, plus infinity
  typedef enum logic [1:0] {
    CLS_SENT = 2'd0,
    CLS_KEY  = 2'd1,
    CLS_EXH  = 2'd2
  } ltkm_cls_e;

  // controller to datapath
  typedef struct packed {
    logic start;     // item accepted and it replays a path
    logic leaf_rd;   // node word is in, fetch the leaf it names
    logic cmp;       // leaf word is in, play the match at this node
    logic out_load;  // move the winner into the output register
  } ltkm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic head_ok;      // head load way is below the active way count
    logic way_zero;     // head load is for way 0
    logic winner_real;  // current winner is a real way, not the sentinel
    logic last_level;   // match being played is at the root
    logic out_free;     // output register can take a result this cycle
  } ltkm_sts_t;

endpackage

### rtl/ltkm_ctrl.sv
// ----------------------------------------------------------------------------
// ltkm_ctrl
// Sequencer of the merge: accepts items, walks the replay one level at a
// time and hands the winner to the output register.
// ----------------------------------------------------------------------------
module ltkm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  ltkm_pkg::ltkm_sts_t sts_i,
  output ltkm_pkg::ltkm_cmd_t cmd_o
);
  import ltkm_pkg::*;

  ltkm_state_e state_q, state_d;
  logic        emit_q, emit_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    emit_d     = emit_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // head loads beyond the way count and refills with no winner are dropped
        if (in_valid_i && (kind_i ? sts_i.winner_real : sts_i.head_ok)) begin
          cmd_o.start = 1'b1;
          emit_d      = kind_i | sts_i.way_zero;
          state_d     = ST_LEAF;
        end
      end
      ST_LEAF: begin
        cmd_o.leaf_rd = 1'b1;
        state_d       = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = sts_i.last_level ? ST_EMIT : ST_LEAF;
      end
      ST_EMIT: begin
        if (emit_q && sts_i.winner_real) begin
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/ltkm_dpath.sv
// ----------------------------------------------------------------------------
// ltkm_dpath
// Datapath of the merge: leaf and loser-node stores, the path walker with
// its running winner, the match comparator and the output register.
// ----------------------------------------------------------------------------
module ltkm_dpath #(
  parameter int unsigned MAX_WAYS = ltkm_pkg::DEF_MAX_WAYS,
  parameter int unsigned KEY_BITS = ltkm_pkg::DEF_KEY_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [ltkm_pkg::CFG_W-1:0]  cfg_wdata_i,
  // input payload
  input  logic                        kind_i,
  input  logic [ltkm_pkg::WAY_W-1:0]  way_i,
  input  logic signed [ltkm_pkg::KEY_W-1:0] key_in_i,
  input  logic                        exhausted_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [ltkm_pkg::KEY_W-1:0] key_out_o,
  output logic [ltkm_pkg::WAY_W-1:0]  winner_way_o,
  output logic                        done_res_o,
  // control
  input  ltkm_pkg::ltkm_cmd_t         cmd_i,
  output ltkm_pkg::ltkm_sts_t         sts_o
);
  import ltkm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WAYS);       // leaf and node address
  localparam int unsigned IW = $clog2(MAX_WAYS + 1);   // way index with sentinel
  localparam int unsigned SW = IW + 1;                 // path start sum
  localparam logic [IW-1:0] SENT = IW'(MAX_WAYS);

  // configuration register
  logic [CFG_W-1:0] num_ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ways_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      num_ways_q <= cfg_wdata_i;
    end
  end

  // active way count, clamped to [2, MAX_WAYS]
  logic [IW-1:0] n_ways;

  always_comb begin
    if (num_ways_q < CFG_W'(2)) begin
      n_ways = IW'(2);
    end else if (32'(num_ways_q) > 32'(MAX_WAYS)) begin
      n_ways = SENT;
    end else begin
      n_ways = IW'(num_ways_q);
    end
  end

  // path start
  logic [IW-1:0] s_q;          // running winner, holds the winner index at rest
  logic [IW-1:0] s_start;
  logic [SW-1:0] start_sum;
  logic [AW-1:0] t_q, t_d;     // node being played
  logic          first_head;

  assign s_start    = kind_i ? s_q : IW'(way_i);
  assign start_sum  = SW'(n_ways) + SW'(s_start);
  assign first_head = !kind_i && (32'(way_i) == 32'(n_ways) - 32'd1);

  // walker state
  logic signed [KEY_BITS-1:0] s_key_q;
  logic [IW-1:0]              other_q, other_d;
  logic [MAX_WAYS-1:0]        node_vld_q;
  logic [MAX_WAYS-1:0]        exh_q;

  // leaf key store
  logic signed [KEY_BITS-1:0] leaf_mem [MAX_WAYS];
  logic signed [KEY_BITS-1:0] leaf_rdata_q;

  // loser node store
  logic [IW-1:0] node_mem [MAX_WAYS];
  logic [IW-1:0] node_rdata_q;

  // next node address: start of path, one level up, or hold
  always_comb begin
    t_d = t_q;
    if (cmd_i.start) begin
      t_d = AW'(start_sum >> 1);
    end else if (cmd_i.cmp) begin
      t_d = t_q >> 1;
    end
  end

  // loser read from the node store; cleared or out-of-range entries act as sentinel
  always_comb begin
    if (!node_vld_q[t_q] || (node_rdata_q > SENT)) begin
      other_d = SENT;
    end else begin
      other_d = node_rdata_q;
    end
  end

  // match: running winner against the stored loser
  ltkm_cls_e cls_s, cls_o;
  logic      s_greater;

  always_comb begin
    cls_s = (s_q == SENT) ? CLS_SENT : (exh_q[s_q[AW-1:0]] ? CLS_EXH : CLS_KEY);
    cls_o = (other_q == SENT) ? CLS_SENT : (exh_q[other_q[AW-1:0]] ? CLS_EXH : CLS_KEY);
    if (cls_s != cls_o) begin
      s_greater = (cls_s > cls_o);
    end else begin
      s_greater = (cls_s == CLS_KEY) && (s_key_q > leaf_rdata_q);
    end
  end

  // memories: written and read on the clock, reads every cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      leaf_mem[s_start[AW-1:0]] <= key_in_i[KEY_BITS-1:0];
    end
    if (cmd_i.cmp && s_greater) begin
      node_mem[t_q] <= s_q;
    end
    leaf_rdata_q <= leaf_mem[other_d[AW-1:0]];
    node_rdata_q <= node_mem[t_d];
  end

  // walker control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q        <= '0;
      t_q        <= '0;
      node_vld_q <= '0;
      exh_q      <= '0;
    end else begin
      t_q <= t_d;
      if (cmd_i.start) begin
        s_q                    <= s_start;
        exh_q[s_start[AW-1:0]] <= exhausted_i;
        if (first_head) begin
          node_vld_q <= '0;
        end
      end else if (cmd_i.cmp && s_greater) begin
        s_q             <= other_q;
        node_vld_q[t_q] <= 1'b1;
      end
    end
  end

  // walker payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      s_key_q <= key_in_i[KEY_BITS-1:0];
    end else if (cmd_i.cmp && s_greater) begin
      s_key_q <= leaf_rdata_q;
    end
    if (cmd_i.leaf_rd) begin
      other_q <= other_d;
    end
  end

  // output register
  logic                     out_valid_q;
  logic signed [KEY_W-1:0]  out_key_q;
  logic [WAY_W-1:0]         out_way_q;
  logic                     out_done_q;
  logic                     win_exh;

  assign win_exh = exh_q[s_q[AW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_key_q  <= win_exh ? '0 : KEY_W'(s_key_q);
      out_way_q  <= WAY_W'(s_q);
      out_done_q <= win_exh;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_out_o    = out_key_q;
  assign winner_way_o = out_way_q;
  assign done_res_o   = out_done_q;

  // status
  always_comb begin
    sts_o.head_ok     = (32'(way_i) < 32'(n_ways));
    sts_o.way_zero    = (way_i == '0);
    sts_o.winner_real = (s_q != SENT);
    sts_o.last_level  = (t_q == AW'(1));
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule

### rtl/loser_tree_kway_merge.sv
// Sequence: an item is accepted, then each tree level on the replayed path does a
//   node read, then a leaf read and the match; last the winner is loaded into the
//   output register if the item emits one. With 16 ways the path has 4 levels.
// Input: a new item is taken only in idle, after the previous replay and its output
//   load, which waits while the output register is full; dropped items stay in idle.
// Reset: asynchronous active low; clears loser nodes to the sentinel, exhausted
//   flags, the winner index (way 0), the output valid and sets num_ways to 16.
// ----------------------------------------------------------------------------
// loser_tree_kway_merge
// K-way ascending merge built on a loser tree with a sequencer and datapath.
// ----------------------------------------------------------------------------
module loser_tree_kway_merge #(
  parameter int unsigned MAX_WAYS = ltkm_pkg::DEF_MAX_WAYS,
  parameter int unsigned KEY_BITS = ltkm_pkg::DEF_KEY_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [ltkm_pkg::CFG_W-1:0]        cfg_wdata_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic [ltkm_pkg::WAY_W-1:0]        way_i,
  input  logic signed [ltkm_pkg::KEY_W-1:0] key_in_i,
  input  logic                              exhausted_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ltkm_pkg::KEY_W-1:0] key_out_o,
  output logic [ltkm_pkg::WAY_W-1:0]        winner_way_o,
  output logic                              done_res_o
);
  import ltkm_pkg::*;

  ltkm_cmd_t cmd;
  ltkm_sts_t sts;

  // sequencer
  ltkm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // stores, comparator and output register
  ltkm_dpath #(
    .MAX_WAYS (MAX_WAYS),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .kind_i       (kind_i),
    .way_i        (way_i),
    .key_in_i     (key_in_i),
    .exhausted_i  (exhausted_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .key_out_o    (key_out_o),
    .winner_way_o (winner_way_o),
    .done_res_o   (done_res_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

### rtl/ltkm_checker.sv
// ----------------------------------------------------------------------------
// ltkm_checker
// Port-level checks of the merge block, bound to the top level.
// ----------------------------------------------------------------------------
module ltkm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [ltkm_pkg::KEY_W-1:0] key_out_o,
  input logic [ltkm_pkg::WAY_W-1:0]        winner_way_o,
  input logic                              done_res_o
);

  // a stalled result transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(key_out_o) && $stable(winner_way_o) && $stable(done_res_o))
    else $error("stalled result changed");

  // an exhausted winner carries a zero key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> key_out_o == '0)
    else $error("done result with nonzero key");

  // results come from the emit state, so none right after an input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("result too soon after input");

  // no new input while a replay is under way
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("input taken during replay");

endmodule

bind loser_tree_kway_merge ltkm_checker u_ltkm_checker (.*);

### tb/tb_loser_tree_kway_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_loser_tree_kway_merge
// Self-checking bench for the loser-tree k-way merge. A short table of
// directed transactions is followed by random merges, broken load sequences
// and noise, under random stalls on both channels. A behavioral copy of the
// tree predicts every winner, and each output transaction is checked in order.
// ----------------------------------------------------------------------------
module tb_loser_tree_kway_merge;
  import ltkm_pkg::*;

  localparam int unsigned MAX_WAYS    = DEF_MAX_WAYS;
  localparam int unsigned SENT_IDX    = MAX_WAYS;
  localparam int unsigned RAND_ITEMS  = 1850;
  localparam int unsigned SETTLE_CYC  = 40;
  localparam int unsigned HOLD_CYC    = 400;
  localparam int unsigned LIMIT_CYC   = 1000000;
  localparam int unsigned SCRIPT_ROWS = 20;

  localparam logic KIND_HEAD   = 1'b0;
  localparam logic KIND_REFILL = 1'b1;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 64'sh7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [WAY_W-1:0]        way;
    logic                    done;
  } winner_t;

  localparam winner_t NO_WIN = '{64'sd0, 4'd0, 1'b0};

  typedef enum logic {ROW_CFG, ROW_ITEM} row_op_e;

  typedef struct packed {
    row_op_e                 op;
    logic [CFG_W-1:0]        cfg;
    logic                    kind;
    logic [WAY_W-1:0]        way;
    logic signed [KEY_W-1:0] key;
    logic                    exh;
    logic                    typed;
    winner_t                 want;
  } row_t;

  // dut signals
  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_W-1:0]        cfg_wdata;
  logic                    in_valid;
  logic                    in_ready;
  logic                    kind;
  logic [WAY_W-1:0]        way;
  logic signed [KEY_W-1:0] key_in;
  logic                    exhausted;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [KEY_W-1:0] key_out;
  logic [WAY_W-1:0]        winner_way;
  logic                    done_res;

  // predictor state
  int unsigned             tree_loser [MAX_WAYS];
  logic signed [KEY_W-1:0] leaf_key [MAX_WAYS];
  bit                      leaf_exh [MAX_WAYS];
  int unsigned             tree_winner;
  logic [CFG_W-1:0]        ways_reg;

  // expected winners, oldest first
  winner_t winner_q [$];
  bit      pred_emit;
  winner_t pred_res;

  // bookkeeping
  int unsigned trans_in, head_cnt, refill_cnt, results_cnt, done_cnt, cfg_writes;
  int unsigned errors;
  int unsigned cycles;
  bit          hold_req, tx_calm, rx_calm;
  row_t        script [SCRIPT_ROWS];

  loser_tree_kway_merge i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .kind_i       (kind),
    .way_i        (way),
    .key_in_i     (key_in),
    .exhausted_i  (exhausted),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .key_out_o    (key_out),
    .winner_way_o (winner_way),
    .done_res_o   (done_res)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ways in use after clamping the register
  function automatic int unsigned active_ways();
    if (ways_reg < 2) return 2;
    if (ways_reg > MAX_WAYS) return MAX_WAYS;
    return ways_reg;
  endfunction

  // order class of a leaf index
  function automatic ltkm_cls_e leaf_cls(input int unsigned idx);
    if (idx >= MAX_WAYS) return CLS_SENT;
    return leaf_exh[idx] ? CLS_EXH : CLS_KEY;
  endfunction

  // play leaf s up to the root, the greater side stays as loser
  function automatic void tree_replay(input int unsigned s);
    int unsigned t;
    int unsigned other;
    ltkm_cls_e   cs, co;
    bit          swap;
    t = (active_ways() + s) / 2;
    while (t > 0) begin
      if (t < MAX_WAYS) begin
        other = tree_loser[t];
        if (other > SENT_IDX) other = SENT_IDX;
        cs = leaf_cls(s);
        co = leaf_cls(other);
        if (cs != co) swap = (cs > co);
        else swap = (cs == CLS_KEY) && (leaf_key[s] > leaf_key[other]);
        if (swap) begin
          tree_loser[t] = s;
          s = other;
        end
      end
      t = t / 2;
    end
    tree_winner = s;
  endfunction

  // apply one input transaction, return 1 with the winner if one is emitted
  function automatic bit merge_step(input logic k, input logic [WAY_W-1:0] w,
                                    input logic signed [KEY_W-1:0] kv, input logic ex,
                                    output winner_t res);
    int unsigned n;
    n = active_ways();
    res = NO_WIN;
    if (k == KIND_HEAD) begin
      if (w >= n) return 1'b0;
      // the highest way opens a new merge
      if (w == n - 1) foreach (tree_loser[i]) tree_loser[i] = SENT_IDX;
      leaf_key[w] = kv;
      leaf_exh[w] = ex;
      tree_replay(w);
      if (w != 0) return 1'b0;
    end else begin
      if (tree_winner >= MAX_WAYS) return 1'b0;
      leaf_key[tree_winner] = kv;
      leaf_exh[tree_winner] = ex;
      tree_replay(tree_winner);
    end
    // sentinel winner means the loads were incomplete
    if (tree_winner >= MAX_WAYS) return 1'b0;
    res.way  = tree_winner[WAY_W-1:0];
    res.done = leaf_exh[tree_winner];
    res.key  = leaf_exh[tree_winner] ? '0 : leaf_key[tree_winner];
    return 1'b1;
  endfunction

  // idle length: mostly short, a few long
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // key mix: extremes, small values for ties, full range
  function automatic logic signed [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 7))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2, 3: return 64'(int'($urandom_range(0, 8)) - 4);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // offer one transaction, predict it once accepted
  task automatic put_item(input logic k, input logic [WAY_W-1:0] w,
                          input logic signed [KEY_W-1:0] kv, input logic ex,
                          input bit typed = 1'b0, input winner_t want = NO_WIN);
    int unsigned gap;
    bit          ignored;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    way       <= w;
    key_in    <= kv;
    exhausted <= ex;
    do @(posedge clk); while (!in_ready);
    ignored = (k == KIND_HEAD) ? (w >= active_ways()) : (tree_winner >= MAX_WAYS);
    if (!ignored) begin
      trans_in++;
      if (k == KIND_HEAD) head_cnt++;
      else refill_cnt++;
    end
    pred_emit = merge_step(k, w, kv, ex, pred_res);
    if (pred_emit) winner_q.push_back(typed ? want : pred_res);
    @(negedge clk);
  endtask

  // stop offering, wait for every winner, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (winner_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // write num_ways while idle
  task automatic write_ways(input logic [CFG_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    ways_reg  = v;
    cfg_writes++;
  endtask

  // stimulus
  initial begin : stim
    int unsigned n, sel, cv;
    int unsigned refills;
    bit          hold_done;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    kind      = 1'b0;
    way       = '0;
    key_in    = '0;
    exhausted = 1'b0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    tx_calm   = 1'b0;
    foreach (tree_loser[i]) begin
      tree_loser[i] = SENT_IDX;
      leaf_key[i]   = '0;
      leaf_exh[i]   = 1'b0;
    end
    tree_winner = 0;
    ways_reg    = CFG_RESET;

    // directed table
    script = '{
      '{ROW_CFG,  5'd2,  KIND_HEAD,   4'd0,  64'sd0,  1'b0, 1'b0, NO_WIN},
      // refill before any load, then refill against the sentinel winner
      '{ROW_ITEM, 5'd0,  KIND_REFILL, 4'd0,  64'sd5,  1'b0, 1'b0, NO_WIN},
      '{ROW_ITEM, 5'd0,  KIND_REFILL, 4'd3,  -64'sd1, 1'b0, 1'b0, NO_WIN},
      // head loads beyond the way count
      '{ROW_ITEM, 5'd0,  KIND_HEAD,   4'd2,  64'sd9,  1'b0, 1'b0, NO_WIN},
      '{ROW_ITEM, 5'd0,  KIND_HEAD,   4'd15, KEY_MAX, 1'b1, 1'b0, NO_WIN},
      // full load with the key extremes
      '{ROW_ITEM, 5'd0,  KIND_HEAD,   4'd1,  KEY_MAX, 1'b0, 1'b0, NO_WIN},
      '{ROW_ITEM, 5'd0,  KIND_HEAD,   4'd0,  KEY_MIN, 1'b0, 1'b1, '{KEY_MIN, 4'd0, 1'b0}},
      // exhaust both ways, then exhausted against exhausted
      '{ROW_ITEM, 5'd0,  KIND_REFILL, 4'd15, 64'sd123, 1'b1, 1'b1, '{KEY_MAX, 4'd1, 1'b0}},
      '{ROW_ITEM, 5'd0,  KIND_REFILL, 4'd0,  64'sd0,  1'b1, 1'b1, '{64'sd0, 4'd1, 1'b1}},
      '{ROW_ITEM, 5'd0,  KIND_REFILL, 4'd7,  KEY_MIN, 1'b1, 1'b1, '{64'sd0, 4'd1, 1'b1}},
      '{ROW_ITEM, 5'd0,  KIND_REFILL, 4'd0,  64'sd0,  1'b0, 1'b0, NO_WIN},
      // ties never swap
      '{ROW_ITEM, 5'd0,  KIND_HEAD,   4'd1,  64'sd7,  1'b0, 1'b0, NO_WIN},
      '{ROW_ITEM, 5'd0,  KIND_HEAD,   4'd0,  64'sd7,  1'b0, 1'b1, '{64'sd7, 4'd0, 1'b0}},
      '{ROW_ITEM, 5'd0,  KIND_REFILL, 4'd1,  64'sd7,  1'b0, 1'b1, '{64'sd7, 4'd0, 1'b0}},
      '{ROW_ITEM, 5'd0,  KIND_REFILL, 4'd0,  -64'sd3, 1'b0, 1'b0, NO_WIN},
      // incomplete load leaves the sentinel on top
      '{ROW_CFG,  5'd4,  KIND_HEAD,   4'd0,  64'sd0,  1'b0, 1'b0, NO_WIN},
      '{ROW_ITEM, 5'd0,  KIND_HEAD,   4'd3,  64'sd10, 1'b0, 1'b0, NO_WIN},
      '{ROW_ITEM, 5'd0,  KIND_HEAD,   4'd0,  64'sd1,  1'b0, 1'b0, NO_WIN},
      '{ROW_ITEM, 5'd0,  KIND_REFILL, 4'd0,  64'sd2,  1'b0, 1'b0, NO_WIN},
      '{ROW_CFG,  5'd31, KIND_HEAD,   4'd0,  64'sd0,  1'b0, 1'b0, NO_WIN}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].op == ROW_CFG) write_ways(script[i].cfg);
      else put_item(script[i].kind, script[i].way, script[i].key, script[i].exh,
                    script[i].typed, script[i].want);
    end

    // random phases, each starts with the block drained
    while (trans_in < RAND_ITEMS) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      if (!hold_done && trans_in >= 600) begin
        // receiver holds off while a full-width merge keeps coming
        write_ways(5'd16);
        tx_calm   = 1'b1;
        hold_req  = 1'b1;
        hold_done = 1'b1;
        sel       = 0;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 9))
            0: begin
              case ($urandom_range(0, 5))
                0: cv = 0;
                1: cv = 1;
                2: cv = 2;
                3: cv = 16;
                4: cv = 17;
                default: cv = 31;
              endcase
            end
            1: cv = $urandom_range(0, 31);
            2, 3: cv = $urandom_range(9, 16);
            default: cv = $urandom_range(2, 8);
          endcase
          write_ways(cv[CFG_W-1:0]);
        end else begin
          settle();
        end
        sel = $urandom_range(0, 9);
      end
      n = active_ways();

      if (sel <= 6) begin
        // well-formed merge: head loads from the top way down, then refills
        for (int w = int'(n) - 1; w >= 0; w--)
          put_item(KIND_HEAD, w[WAY_W-1:0], rand_key(), $urandom_range(0, 11) == 0);
        refills = 0;
        while (!(pred_emit && pred_res.done) && refills < 400) begin
          put_item(KIND_REFILL, 4'($urandom()), rand_key(), $urandom_range(0, 3) == 0);
          refills++;
        end
        if ($urandom_range(0, 3) == 0)
          put_item(KIND_REFILL, 4'($urandom()), rand_key(), 1'($urandom_range(0, 1)));
      end else if (sel == 7) begin
        // broken sequence: partial loads in any order, then refills
        repeat ($urandom_range(1, n))
          put_item(KIND_HEAD, 4'($urandom_range(0, n - 1)), rand_key(),
                   $urandom_range(0, 5) == 0);
        repeat ($urandom_range(0, 6))
          put_item(KIND_REFILL, 4'($urandom()), rand_key(), $urandom_range(0, 3) == 0);
      end else begin
        // noise over every field
        repeat (24)
          put_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), rand_key(),
                   1'($urandom_range(0, 1)));
      end
    end

    settle();
    $display("summary: %0d transactions in (%0d head loads, %0d refills), %0d config writes",
             trans_in, head_cnt, refill_cnt, cfg_writes);
    $display("summary: %0d winners checked, %0d merges run to exhaustion, %0d errors",
             results_cnt, done_cnt, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver: random stalls, calm stretches and one long hold-off
  initial begin : sink
    int unsigned gap;
    out_ready = 1'b0;
    rx_calm   = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_calm = ~rx_calm;
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        gap = pick_gap(rx_calm);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  // check each output transaction against the oldest expected winner
  always @(posedge clk) begin : check
    winner_t want;
    if (rst_n && out_valid && out_ready) begin
      results_cnt++;
      if (winner_q.size() == 0) begin
        $display("%0t: unexpected winner key %0d way %0d done %0d",
                 $time, key_out, winner_way, done_res);
        errors++;
      end else begin
        want = winner_q.pop_front();
        if (want.done) done_cnt++;
        if (key_out !== want.key) begin
          $display("%0t: key_out mismatch, expected %0d actual %0d", $time, want.key, key_out);
          errors++;
        end
        if (winner_way !== want.way) begin
          $display("%0t: winner_way mismatch, expected %0d actual %0d",
                   $time, want.way, winner_way);
          errors++;
        end
        if (done_res !== want.done) begin
          $display("%0t: done_res mismatch, expected %0d actual %0d",
                   $time, want.done, done_res);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYC) begin
      $display("%0t: run limit reached, %0d winners still expected", $time, winner_q.size());
      $display("tb: failure");
      $finish;
    end
  end

endmodule

### files.f
rtl/ltkm_pkg.sv
rtl/ltkm_ctrl.sv
rtl/ltkm_dpath.sv
rtl/loser_tree_kway_merge.sv
rtl/ltkm_checker.sv
tb/tb_loser_tree_kway_merge.sv
